// ===== rtl/core/cpr_pkg.sv =====
// Shared constants for the clock page replacement core.
`default_nettype none
package cpr_pkg;

  // transaction kind codes
  localparam logic KIND_REF   = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  // fixed port widths
  localparam int PAGE_W  = 16;
  localparam int FRAME_W = 4;

endpackage
`default_nettype wire

// ===== rtl/core/cpr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module cpr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/core/clock_page_replacement_core.sv =====
// Second-chance (clock) page replacement core: frame table, lookup and sweep sequencer.
// A clear answers directly from IDLE without a lookup. A reference walks the frame table
// through the single frame memory read port, one frame per cycle, in order from frame 0;
// a hit ends the walk at the matching frame. A miss with a free frame fills the next free
// frame; otherwise the clock hand sweeps, dropping set reference bits, stops on the victim,
// reads its page and replaces it. Start is taken only in IDLE, so one transaction runs at a
// time; busy is high while a reference is in flight.
// Reset clears reference bits, clock hand and fill count at once; no clearing pass.
`default_nettype none
module clock_page_replacement_core
  import cpr_pkg::*;
#(
  parameter int FRAMES    = 16,
  parameter int PAGE_BITS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic              kind,
  input  wire logic [PAGE_W-1:0] page_number,
  output logic                   done,
  output logic                   hit,
  output logic [FRAME_W-1:0]     frame,
  output logic                   evicted_valid,
  output logic [PAGE_W-1:0]      evicted_page
);

  localparam int SW = (PAGE_BITS < PAGE_W) ? PAGE_BITS : PAGE_W;
  localparam int AW = $clog2(FRAMES);
  localparam int CW = $clog2(FRAMES + 1);

  typedef enum logic [1:0] {IDLE, SCAN, SWEEP, EVICT} state_t;

  state_t          state;
  logic [SW-1:0]   pg;
  logic [CW-1:0]   idx;
  logic [CW-1:0]   filled;
  logic [AW-1:0]   pidx;
  logic            pv;
  logic [AW-1:0]   hand;
  logic [FRAMES-1:0] ref_bits;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [AW-1:0]   ram_raddr;
  logic [SW-1:0]   ram_rdata;

  logic            match;
  logic            scan_end;
  logic            has_free;
  logic [AW-1:0]   hand_inc;

  assign busy     = (state != IDLE);
  assign match    = pv && (ram_rdata == pg);
  assign scan_end = (idx == filled) && !pv;
  assign has_free = (filled < CW'(FRAMES));
  assign hand_inc = (hand == AW'(FRAMES - 1)) ? '0 : hand + AW'(1);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = filled[AW-1:0];
    ram_raddr = idx[AW-1:0];
    unique case (state)
      SCAN: begin
        ram_we = !match && scan_end && has_free;
      end
      SWEEP: begin
        ram_raddr = hand;
      end
      EVICT: begin
        ram_we    = 1'b1;
        ram_waddr = hand;
      end
      default: begin
      end
    endcase
  end

  cpr_ram #(
    .WIDTH(SW),
    .DEPTH(FRAMES)
  ) u_frame_pages (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(pg),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      done     <= 1'b0;
      pv       <= 1'b0;
      hand     <= '0;
      filled   <= '0;
      ref_bits <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        IDLE: begin
          if (start) begin
            if (kind == KIND_CLEAR) begin
              ref_bits      <= '0;
              hit           <= 1'b0;
              frame         <= '0;
              evicted_valid <= 1'b0;
              evicted_page  <= '0;
              done          <= 1'b1;
            end else begin
              pg    <= page_number[SW-1:0];
              idx   <= '0;
              pv    <= 1'b0;
              state <= SCAN;
            end
          end
        end
        SCAN: begin
          if (match) begin
            // lowest matching frame wins since frames are read in order
            ref_bits[pidx] <= 1'b1;
            hit            <= 1'b1;
            frame          <= FRAME_W'(pidx);
            evicted_valid  <= 1'b0;
            evicted_page   <= '0;
            done           <= 1'b1;
            pv             <= 1'b0;
            state          <= IDLE;
          end else if (scan_end) begin
            if (has_free) begin
              ref_bits[filled[AW-1:0]] <= 1'b1;
              filled        <= filled + CW'(1);
              hit           <= 1'b0;
              frame         <= FRAME_W'(filled);
              evicted_valid <= 1'b0;
              evicted_page  <= '0;
              done          <= 1'b1;
              state         <= IDLE;
            end else begin
              state <= SWEEP;
            end
          end else begin
            pv   <= (idx < filled);
            pidx <= idx[AW-1:0];
            if (idx < filled) begin
              idx <= idx + CW'(1);
            end
          end
        end
        SWEEP: begin
          // give a second chance: drop the bit and advance; hold on a clear bit
          if (ref_bits[hand]) begin
            ref_bits[hand] <= 1'b0;
            hand           <= hand_inc;
          end else begin
            state <= EVICT;
          end
        end
        EVICT: begin
          ref_bits[hand] <= 1'b1;
          hand           <= hand_inc;
          hit            <= 1'b0;
          frame          <= FRAME_W'(hand);
          evicted_valid  <= 1'b1;
          evicted_page   <= PAGE_W'(ram_rdata);
          done           <= 1'b1;
          state          <= IDLE;
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/cpr_checker.sv =====
// Port-level checker for the clock page replacement core, bound to the top level.
`default_nettype none
module cpr_checker
  import cpr_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               start,
  input wire logic               busy,
  input wire logic               kind,
  input wire logic               done,
  input wire logic               hit,
  input wire logic [FRAME_W-1:0] frame,
  input wire logic               evicted_valid
);

  // a result is never both a hit and an eviction
  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    done |-> !(hit && evicted_valid))
    else $error("hit and eviction reported together");

  // a clear transaction answers in the next cycle with an empty result
  a_clear_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && kind == KIND_CLEAR) |=>
      (done && !hit && !evicted_valid && frame == '0 && !busy))
    else $error("clear transaction result wrong");

  // a page reference keeps the core busy after acceptance
  a_ref_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && kind == KIND_REF) |=> (busy && !done))
    else $error("reference transaction did not start");

  // a result comes only from a transaction in flight
  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(busy) || $past(start)))
    else $error("result without transaction");

endmodule

bind clock_page_replacement_core cpr_checker u_cpr_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .kind         (kind),
  .done         (done),
  .hit          (hit),
  .frame        (frame),
  .evicted_valid(evicted_valid)
);
`default_nettype wire
